FILE: src/multi_hash_key_value_table_unit_assert.svh
// Assertion helpers for the table's RTL modules; the controller includes them.
// Each expects clk_i and rst_ni to be visible where it is used.
`ifndef MULTI_HASH_KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define MULTI_HASH_KEY_VALUE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MHKV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MHKV_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mhkv_pkg.sv
`default_nettype none

package mhkv_pkg;

  // Table geometry and hashing.
  localparam int NumHashes  = 4;
  localparam int NumMults   = 4;
  localparam int NumProbes  = (NumHashes > NumMults) ? NumMults : NumHashes;
  localparam int TableDepth = 1024;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int SizeW      = 11;
  localparam int KeyW       = 32;
  localparam int ValW       = 32;
  localparam int MultW      = 32;
  localparam int ProbeW     = 2;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 32;

  // Remainder unit: bits of the dividend retired per cycle.
  localparam int ModBitsPerCycle = 4;
  localparam int ModCycles       = KeyW / ModBitsPerCycle;
  localparam int ModCntW         = $clog2(ModCycles);

  // Reset values of the configuration registers.
  localparam logic [SizeW-1:0] SizeReset = SizeW'(TableDepth);
  localparam logic [MultW-1:0] MultReset [NumMults] = '{32'd1, 32'd3, 32'd5, 32'd7};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TABLE_SIZE = 3'd0,
    CFG_MULT_A     = 3'd1,
    CFG_MULT_B     = 3'd2,
    CFG_MULT_C     = 3'd3,
    CFG_MULT_D     = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_REFUSED  = 2'd1,
    STAT_FOUND    = 2'd2,
    STAT_MISS     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_MUL,
    CS_START,
    CS_MOD,
    CS_READ,
    CS_CHECK,
    CS_RESP
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clr_en;
    logic    in_ready;
    logic    load;
    logic    mul_en;
    logic    mod_start;
    logic    rd_en;
    logic    wr_en;
    logic    probe_next;
    logic    set_res;
    status_e res_code;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic key_zero;
    logic is_lookup;
    logic mod_done;
    logic key_empty;
    logic key_match;
    logic clr_last;
    logic last_probe;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/mhkv_mod.sv
`default_nettype none

module mhkv_mod
  import mhkv_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [KeyW-1:0]  dividend_i,
  input  wire logic [SizeW-1:0] divisor_i,
  output logic                  done_o,
  output logic [AddrW-1:0]      rem_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [ModCntW-1:0]  cnt_q, cnt_d;
  logic [KeyW-1:0]     dvd_q, dvd_d;
  logic [SizeW-1:0]    rem_q, rem_d;
  logic [SizeW-1:0]    step_rem;

  // Restoring remainder, ModBitsPerCycle dividend bits per cycle, most significant first.
  always_comb begin
    logic [SizeW:0] t;
    step_rem = rem_q;
    for (int k = 0; k < ModBitsPerCycle; k++) begin
      t = {step_rem, dvd_q[KeyW-1-k]};
      if (t >= {1'b0, divisor_i}) begin
        t = t - {1'b0, divisor_i};
      end
      step_rem = t[SizeW-1:0];
    end
  end

  // Sequencing of the iterations.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = step_rem;
      dvd_d = dvd_q << ModBitsPerCycle;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ModCntW'(ModCycles - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[AddrW-1:0];

endmodule

`default_nettype wire

FILE: src/mhkv_dpath.sv
`default_nettype none

module mhkv_dpath
  import mhkv_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  input  wire logic [KeyW+ValW-1:0] in_data_i,
  input  wire logic                 in_user_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [ValW-1:0]           out_data_o,
  output logic [1:0]                out_user_o
);

  // Configuration registers; the table size is kept already clamped.
  logic [SizeW-1:0] size_q;
  logic [MultW-1:0] mult_q [NumMults];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
      for (int i = 0; i < NumMults; i++) begin
        mult_q[i] <= MultReset[i];
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TABLE_SIZE: begin
          if (cfg_data_i[SizeW-1:0] == '0) begin
            size_q <= SizeW'(1);
          end else if (32'(cfg_data_i[SizeW-1:0]) > 32'(TableDepth)) begin
            size_q <= SizeW'(TableDepth);
          end else begin
            size_q <= cfg_data_i[SizeW-1:0];
          end
        end
        CFG_MULT_A: mult_q[0] <= cfg_data_i;
        CFG_MULT_B: mult_q[1] <= cfg_data_i;
        CFG_MULT_C: mult_q[2] <= cfg_data_i;
        CFG_MULT_D: mult_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request capture.
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;
  op_e             op_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= in_data_i[KeyW-1:0];
      val_q <= in_data_i[KeyW+ValW-1:KeyW];
      op_q  <= op_e'(in_user_i);
    end
  end

  // Probe counter.
  logic [ProbeW-1:0] probe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else if (cmd_i.load) begin
      probe_q <= '0;
    end else if (cmd_i.probe_next) begin
      probe_q <= probe_q + 1'b1;
    end
  end

  // Hash product, wrapped to the key width.
  logic [KeyW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= KeyW'(key_q * mult_q[probe_q]);
    end
  end

  // Bucket index is the product modulo the table size.
  logic             mod_done;
  logic [AddrW-1:0] bucket;

  mhkv_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (prod_q),
    .divisor_i  (size_q),
    .done_o     (mod_done),
    .rem_o      (bucket)
  );

  // Clearing pass over the key store after reset.
  logic [AddrW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // Key and value stores, one write and one registered read each.
  logic [KeyW-1:0]  key_mem [TableDepth];
  logic [ValW-1:0]  val_mem [TableDepth];
  logic [KeyW-1:0]  key_rd_q;
  logic [ValW-1:0]  val_rd_q;
  logic [AddrW-1:0] key_wr_addr;
  logic [KeyW-1:0]  key_wr_data;

  assign key_wr_addr = cmd_i.clr_en ? clr_addr_q : bucket;
  assign key_wr_data = cmd_i.clr_en ? '0 : key_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en || cmd_i.wr_en) begin
      key_mem[key_wr_addr] <= key_wr_data;
    end
    if (cmd_i.rd_en) begin
      key_rd_q <= key_mem[bucket];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      val_mem[bucket] <= val_q;
    end
    if (cmd_i.rd_en) begin
      val_rd_q <= val_mem[bucket];
    end
  end

  // Result register, parting the work from the receiver.
  logic            out_valid_q;
  status_e         res_code_q;
  logic [ValW-1:0] res_val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_res) begin
      res_code_q <= cmd_i.res_code;
      res_val_q  <= (cmd_i.res_code == STAT_FOUND) ? val_rd_q : '0;
    end
  end

  logic [ValW-1:0] out_data_q;
  logic [1:0]      out_user_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= res_val_q;
      out_user_q <= res_code_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  // Status toward the controller.
  always_comb begin
    sts_o            = '0;
    sts_o.key_zero   = (key_q == '0);
    sts_o.is_lookup  = (op_q == OP_LOOKUP);
    sts_o.mod_done   = mod_done;
    sts_o.key_empty  = (key_rd_q == '0);
    sts_o.key_match  = (key_rd_q == key_q);
    sts_o.clr_last   = (clr_addr_q == AddrW'(TableDepth - 1));
    sts_o.last_probe = (probe_q == ProbeW'(NumProbes - 1));
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

FILE: src/mhkv_ctrl.sv
`default_nettype none
`include "multi_hash_key_value_table_unit_assert.svh"

module mhkv_ctrl
  import mhkv_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.res_code = STAT_REFUSED;
    unique case (state_q)
      CS_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = CS_IDLE;
        end
      end
      CS_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = CS_MUL;
        end
      end
      CS_MUL: begin
        // A zero key is refused without touching the table.
        if (sts_i.key_zero) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = STAT_REFUSED;
          state_d        = CS_RESP;
        end else begin
          cmd_o.mul_en = 1'b1;
          state_d      = CS_START;
        end
      end
      CS_START: begin
        cmd_o.mod_start = 1'b1;
        state_d         = CS_MOD;
      end
      CS_MOD: begin
        if (sts_i.mod_done) begin
          state_d = CS_READ;
        end
      end
      CS_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = CS_CHECK;
      end
      CS_CHECK: begin
        if (!sts_i.is_lookup && sts_i.key_empty) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = STAT_INSERTED;
          state_d        = CS_RESP;
        end else if (sts_i.is_lookup && sts_i.key_match) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = STAT_FOUND;
          state_d        = CS_RESP;
        end else if (sts_i.last_probe) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = sts_i.is_lookup ? STAT_MISS : STAT_REFUSED;
          state_d        = CS_RESP;
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d          = CS_MUL;
        end
      end
      CS_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = CS_IDLE;
        end
      end
      default: state_d = CS_CLEAR;
    endcase
  end

  `MHKV_ASSERT_IMP(a_load_when_free, cmd_o.out_load, sts_i.out_free, "result loaded over pending beat")
  `MHKV_ASSERT_IMP(a_write_empty_insert, cmd_o.wr_en, !sts_i.is_lookup && sts_i.key_empty && !sts_i.key_zero, "bad table write")
  `MHKV_ASSERT_NXT(a_accept_busy, cmd_o.load, !cmd_o.in_ready, "second beat taken while busy")
  `MHKV_ASSERT_NXT(a_mod_restart, cmd_o.mod_start, !sts_i.mod_done, "stale remainder seen as done")

endmodule

`default_nettype wire

FILE: src/multi_hash_key_value_table_unit.sv
// Multiple-choice hash table, one key-value pair per bucket.
// Input channel s_axis: tuser is the opcode (insert or lookup), tdata carries
// the key in bits 31:0 and the signed value in bits 63:32.
// Output channel m_axis: one beat per input beat, tuser is the status
// (inserted, refused, found, not found), tdata is the stored value on a hit.
// Configuration channel cfg: index 0 table size, 1 to 4 the probe multipliers;
// writes are taken every cycle and are meant to land while the table is idle.
// Each probe passes through a multiply step, a start step, the shared remainder
// unit (8 steps of 4 bits each, then a done flag), a memory read and a check.
// A zero key is refused without a probe; any other key is tried with one to
// four probes. A new beat is accepted only once the previous result has been
// moved to the output register.
// After reset the key store is cleared, one bucket per cycle, across all 1024
// buckets before the first beat is accepted.
// A finished result sits in the output register; the next beat is accepted
// meanwhile, and its result waits until the receiver takes the earlier one.

`default_nettype none

module multi_hash_key_value_table_unit
  import mhkv_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Input beat.
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [KeyW+ValW-1:0] s_axis_tdata,  // key [31:0], value [63:32]
  input  wire logic                 s_axis_tuser,  // opcode [0]
  // Result beat.
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [ValW-1:0]           m_axis_tdata,  // read_value [31:0]
  output logic [1:0]                m_axis_tuser,  // status [1:0]
  // Register writes.
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign s_axis_tready = cmd.in_ready;
  assign cfg_ready_o   = 1'b1;

  mhkv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mhkv_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire
